@@ rtl/ghs_pkg.sv @@
`timescale 1ns / 1ps

package ghs_pkg;

  typedef enum logic [2:0] {
    PH_FIXED   = 3'd0,
    PH_XLEN    = 3'd1,
    PH_XDATA   = 3'd2,
    PH_NAME    = 3'd3,
    PH_COMMENT = 3'd4,
    PH_HCRC    = 3'd5,
    PH_BODY    = 3'd6
  } ghs_phase_e;

  typedef enum logic [1:0] {
    ST_HDR   = 2'd0,
    ST_BODY  = 2'd1,
    ST_ERR   = 2'd2,
    ST_AFTER = 2'd3
  } ghs_status_e;

  typedef struct packed {
    ghs_status_e status;
    logic [7:0]  body_byte;
    logic        chunk_end;
  } ghs_res_t;

  typedef struct packed {
    logic       err_seen;
    ghs_phase_e phase;
  } ghs_front_stat_t;

  localparam logic [7:0] Magic0    = 8'h1F;
  localparam logic [7:0] Magic1    = 8'h8B;
  localparam logic [7:0] MethodDfl = 8'h08;
  localparam logic [7:0] FlgRsvd   = 8'hE0;

  localparam logic [3:0] FlHcrc    = 4'h1;
  localparam logic [3:0] FlExtra   = 4'h2;
  localparam logic [3:0] FlName    = 4'h4;
  localparam logic [3:0] FlComment = 4'h8;

  localparam logic [3:0] FixedLast = 4'd9;

  // next optional field at or after from that is present
  function automatic ghs_phase_e first_present(ghs_phase_e from, logic [3:0] flags);
    ghs_phase_e ph;
    if (from <= PH_XLEN && (flags & FlExtra) != 4'h0) begin
      ph = PH_XLEN;
    end else if (from <= PH_NAME && (flags & FlName) != 4'h0) begin
      ph = PH_NAME;
    end else if (from <= PH_COMMENT && (flags & FlComment) != 4'h0) begin
      ph = PH_COMMENT;
    end else if (from <= PH_HCRC && (flags & FlHcrc) != 4'h0) begin
      ph = PH_HCRC;
    end else begin
      ph = PH_BODY;
    end
    return ph;
  endfunction

endpackage

@@ rtl/gzip_header_stripper_top.sv @@
// an accepted beat is written into the queue, then moves to the output register that drives out_valid_o
// throughput: one beat per cycle while the queue is not full; the parser state updates once per accepted beat
// a two-entry queue between parser and output register absorbs output stalls
// reset: asynchronous, active low; parser returns to the fixed header, error clears
// queue and output register come up empty
`timescale 1ns / 1ps

module gzip_header_stripper_top #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       chunk_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [7:0] body_byte_o,
  output logic       chunk_end_out_o
);
  import ghs_pkg::*;

  localparam int ResW = $bits(ghs_res_t);
  localparam int CntW = $clog2(QueueDepth + 1);

  logic            push, pop, full, empty;
  ghs_res_t        push_data, head;
  ghs_front_stat_t front_stat;
  logic [CntW-1:0] q_count;

  ghs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .chunk_end_i (chunk_end_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data),
    .stat_o      (front_stat)
  );

  ghs_fifo #(
    .Width (ResW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty),
    .count_o     (q_count)
  );

  ghs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .body_byte_o     (body_byte_o),
    .chunk_end_out_o (chunk_end_out_o)
  );

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(front_stat.err_seen))
    else $error("header error flag cleared without reset");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CntW'(QueueDepth))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !full)
    else $error("beat accepted into a full queue");

  a_body_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_BODY) |-> (body_byte_o == 8'd0))
    else $error("body byte nonzero on a non-body beat");

  a_err_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && push_data.status == ST_ERR) |=> front_stat.err_seen)
    else $error("error beat did not set the sticky flag");

endmodule

@@ rtl/ghs_front.sv @@
`timescale 1ns / 1ps

module ghs_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     chunk_end_i,
  input  logic                     full_i,
  output logic                     push_o,
  output ghs_pkg::ghs_res_t        push_data_o,
  output ghs_pkg::ghs_front_stat_t stat_o
);
  import ghs_pkg::*;

  ghs_phase_e  phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [3:0]  flags_q, flags_d;
  logic [15:0] xrem_q, xrem_d;
  logic [7:0]  xlow_q, xlow_d;
  logic        err_q, err_d;
  logic        bad;
  logic        accept;
  ghs_res_t    res;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;
  assign push_data_o = res;
  assign stat_o     = '{err_seen: err_q, phase: phase_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIXED;
      cnt_q   <= 4'd0;
      flags_q <= 4'd0;
      xrem_q  <= 16'd0;
      xlow_q  <= 8'd0;
      err_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      flags_q <= flags_d;
      xrem_q  <= xrem_d;
      xlow_q  <= xlow_d;
      err_q   <= err_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    flags_d = flags_q;
    xrem_d  = xrem_q;
    xlow_d  = xlow_q;
    err_d   = err_q;
    bad     = 1'b0;
    res.status    = ST_HDR;
    res.body_byte = 8'd0;
    res.chunk_end = chunk_end_i;
    if (err_q) begin
      res.status = ST_AFTER;
    end else begin
      unique case (phase_q)
        PH_FIXED: begin
          if (cnt_q == 4'd0) begin
            bad = (data_byte_i != Magic0);
          end else if (cnt_q == 4'd1) begin
            bad = (data_byte_i != Magic1);
          end else if (cnt_q == 4'd2) begin
            bad = (data_byte_i != MethodDfl);
          end else if (cnt_q == 4'd3) begin
            if ((data_byte_i & FlgRsvd) != 8'd0) begin
              bad = 1'b1;
            end else begin
              flags_d = data_byte_i[4:1];
            end
          end
          if (bad) begin
            err_d      = 1'b1;
            res.status = ST_ERR;
          end else if (cnt_q >= FixedLast) begin
            cnt_d   = 4'd0;
            phase_d = first_present(PH_XLEN, flags_q);
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
        PH_XLEN: begin
          if (cnt_q == 4'd0) begin
            xlow_d = data_byte_i;
            cnt_d  = 4'd1;
          end else begin
            xrem_d  = {data_byte_i, xlow_q};
            cnt_d   = 4'd0;
            phase_d = (xrem_d != 16'd0) ? PH_XDATA : first_present(PH_NAME, flags_q);
          end
        end
        PH_XDATA: begin
          if (xrem_q != 16'd0) begin
            xrem_d = xrem_q - 16'd1;
          end
          if (xrem_d == 16'd0) begin
            phase_d = first_present(PH_NAME, flags_q);
          end
        end
        PH_NAME: begin
          if (data_byte_i == 8'd0) begin
            phase_d = first_present(PH_COMMENT, flags_q);
          end
        end
        PH_COMMENT: begin
          if (data_byte_i == 8'd0) begin
            phase_d = first_present(PH_HCRC, flags_q);
          end
        end
        PH_HCRC: begin
          if (cnt_q == 4'd0) begin
            cnt_d = 4'd1;
          end else begin
            cnt_d   = 4'd0;
            phase_d = PH_BODY;
          end
        end
        default: begin
          res.status    = ST_BODY;
          res.body_byte = data_byte_i;
        end
      endcase
    end
  end

endmodule

@@ rtl/ghs_fifo.sv @@
`timescale 1ns / 1ps

module ghs_fifo #(
  parameter int Width = 11,
  parameter int Depth = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           push_data_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           head_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == CntW'(0));
  assign count_o = cnt_q;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? PtrW'(0) : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? PtrW'(0) : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/ghs_back.sv @@
`timescale 1ns / 1ps

module ghs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  ghs_pkg::ghs_res_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [7:0]        body_byte_o,
  output logic              chunk_end_out_o
);
  import ghs_pkg::*;

  logic     valid_q;
  ghs_res_t out_q;

  // refill the output register when it is empty or its beat is taken
  assign pop_o = !empty_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= head_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign status_o        = out_q.status;
  assign body_byte_o     = out_q.body_byte;
  assign chunk_end_out_o = out_q.chunk_end;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import ghs_pkg::*;

  class strip_scoreboard;
    ghs_phase_e phase = PH_FIXED;
    logic [3:0] hdr_idx = 4'd0;
    logic [3:0] opt_flags = 4'h0;
    logic [15:0] extra_left = 16'h0000;
    logic [7:0] extra_lo = 8'h00;
    bit hdr_error = 1'b0;
    ghs_res_t pending[$];
    int failures = 0;

    function void flag_failure(string msg);
      failures++;
      if (failures <= 10) begin
        $display("%s", msg);
      end
    endfunction

    // first optional field at or after from whose flag is set
    function ghs_phase_e next_field(ghs_phase_e from);
      ghs_phase_e ph;
      ph = from;
      while (ph != PH_BODY) begin
        if ((ph == PH_XLEN && (opt_flags & FlExtra) != 4'h0) ||
            (ph == PH_NAME && (opt_flags & FlName) != 4'h0) ||
            (ph == PH_COMMENT && (opt_flags & FlComment) != 4'h0) ||
            (ph == PH_HCRC && (opt_flags & FlHcrc) != 4'h0)) begin
          return ph;
        end
        ph = ghs_phase_e'(ph + 1);
      end
      return PH_BODY;
    endfunction

    function void take_byte(logic [7:0] b, logic ce);
      ghs_res_t r;
      bit bad;
      r.status = ST_HDR;
      r.body_byte = 8'h00;
      r.chunk_end = ce;
      bad = 1'b0;
      if (hdr_error) begin
        r.status = ST_AFTER;
      end else begin
        case (phase)
          PH_FIXED: begin
            case (hdr_idx)
              4'd0: bad = (b != Magic0);
              4'd1: bad = (b != Magic1);
              4'd2: bad = (b != MethodDfl);
              4'd3: begin
                bad = ((b & FlgRsvd) != 8'h00);
                if (!bad) begin
                  opt_flags = b[4:1];
                end
              end
              default: ;
            endcase
            if (bad) begin
              hdr_error = 1'b1;
              r.status = ST_ERR;
            end else if (hdr_idx >= FixedLast) begin
              hdr_idx = 4'd0;
              phase = next_field(PH_XLEN);
            end else begin
              hdr_idx++;
            end
          end
          PH_XLEN: begin
            if (hdr_idx == 4'd0) begin
              extra_lo = b;
              hdr_idx = 4'd1;
            end else begin
              extra_left = {b, extra_lo};
              hdr_idx = 4'd0;
              phase = (extra_left != 16'h0000) ? PH_XDATA : next_field(PH_NAME);
            end
          end
          PH_XDATA: begin
            if (extra_left != 16'h0000) begin
              extra_left--;
            end
            if (extra_left == 16'h0000) begin
              phase = next_field(PH_NAME);
            end
          end
          PH_NAME: begin
            if (b == 8'h00) begin
              phase = next_field(PH_COMMENT);
            end
          end
          PH_COMMENT: begin
            if (b == 8'h00) begin
              phase = next_field(PH_HCRC);
            end
          end
          PH_HCRC: begin
            if (hdr_idx == 4'd0) begin
              hdr_idx = 4'd1;
            end else begin
              hdr_idx = 4'd0;
              phase = PH_BODY;
            end
          end
          default: begin
            r.status = ST_BODY;
            r.body_byte = b;
          end
        endcase
      end
      pending.push_back(r);
    endfunction

    function void check_beat(logic [1:0] st, logic [7:0] bb, logic ce);
      ghs_res_t want;
      if (pending.size() == 0) begin
        flag_failure($sformatf("unexpected beat: status %0d body %02h chunk_end %0b",
                               st, bb, ce));
        return;
      end
      want = pending.pop_front();
      if (want.status != st || want.body_byte != bb || want.chunk_end != ce) begin
        flag_failure($sformatf({"beat mismatch: exp status %0d body %02h chunk_end %0b, ",
                                "got status %0d body %02h chunk_end %0b"},
                               want.status, want.body_byte, want.chunk_end, st, bb, ce));
      end
    endfunction
  endclass

  localparam int CycleLimit = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] data_byte_i = 8'h00;
  logic chunk_end_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [7:0] body_byte_o;
  logic chunk_end_out_o;

  strip_scoreboard sb = new();
  logic [7:0] gz_stream[$];
  int burst_left = 0;
  int cycles = 0;
  int ready_pct = 100;

  gzip_header_stripper_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .chunk_end_i    (chunk_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .body_byte_o    (body_byte_o),
    .chunk_end_out_o(chunk_end_out_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // receiver: ready duty is redrawn from 100, 80, 50 or 25 percent, and out_ready_i is drawn against it
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct <= 100;
        1: ready_pct <= 50;
        2: ready_pct <= 25;
        default: ready_pct <= 80;
      endcase
    end
    out_ready_i <= ($urandom_range(1, 100) <= ready_pct);
    if (cycles == CycleLimit) begin
      $display("gzip_header_stripper_top verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.take_byte(data_byte_i, chunk_end_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_beat(status_o, body_byte_o, chunk_end_out_o);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic ce);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    chunk_end_i <= ce;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic push_text_field();
    int len;
    len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20);
    repeat (len) gz_stream.push_back(8'($urandom_range(1, 255)));
    gz_stream.push_back(8'h00);
  endtask

  initial begin
    logic [7:0] flg;
    int xlen;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fixed header
    flg = 8'($urandom_range(0, 31));
    if ($urandom_range(0, 2) != 0) begin
      flg[4:1] = 4'hF;
    end
    gz_stream.push_back(Magic0);
    gz_stream.push_back(Magic1);
    gz_stream.push_back(MethodDfl);
    gz_stream.push_back(flg);
    gz_stream.push_back(8'h00);
    gz_stream.push_back(8'hFF);
    repeat (4) gz_stream.push_back(8'($urandom_range(0, 255)));

    // optional fields in stream order
    if ((flg[4:1] & FlExtra) != 4'h0) begin
      case ($urandom_range(0, 15))
        0: xlen = 0;
        1: xlen = 255;
        2: xlen = 1;
        3: xlen = 256;
        default: xlen = $urandom_range(2, 60);
      endcase
      gz_stream.push_back(xlen[7:0]);
      gz_stream.push_back(xlen[15:8]);
      repeat (xlen) gz_stream.push_back(8'($urandom_range(0, 255)));
    end
    if ((flg[4:1] & FlName) != 4'h0) begin
      push_text_field();
    end
    if ((flg[4:1] & FlComment) != 4'h0) begin
      push_text_field();
    end
    if ((flg[4:1] & FlHcrc) != 4'h0) begin
      repeat (2) gz_stream.push_back(8'($urandom_range(0, 255)));
    end

    // body
    gz_stream.push_back(8'h00);
    gz_stream.push_back(8'hFF);
    gz_stream.push_back(Magic0);
    gz_stream.push_back(Magic1);
    gz_stream.push_back(MethodDfl);
    repeat (340) gz_stream.push_back(8'($urandom_range(0, 255)));

    // occasionally corrupt one checked byte of the fixed header
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: gz_stream[0] = Magic0 ^ 8'($urandom_range(1, 255));
        1: gz_stream[1] = Magic1 ^ 8'($urandom_range(1, 255));
        2: gz_stream[2] = MethodDfl ^ 8'($urandom_range(1, 255));
        default: gz_stream[3] = flg | 8'($urandom_range(1, 7) << 5);
      endcase
    end

    foreach (gz_stream[i]) begin
      send_byte(gz_stream[i], $urandom_range(0, 3) == 0);
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      sb.flag_failure($sformatf("%0d results never arrived", sb.pending.size()));
    end
    if (sb.failures == 0) begin
      $display("gzip_header_stripper_top verification clean");
    end else begin
      $display("gzip_header_stripper_top verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ghs_pkg.sv
rtl/ghs_front.sv
rtl/ghs_fifo.sv
rtl/ghs_back.sv
rtl/gzip_header_stripper_top.sv
tb/tb_top.sv
